>>> hw/rtl/pmtu_pkg.sv
package pmtu_pkg;

  localparam int unsigned SizeW  = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 8;
  localparam int unsigned OutDataW = 56;

  localparam logic [SizeW-1:0]  BaseSizeRst = 16'd1200;
  localparam logic [CountW-1:0] RetryRst    = 8'd3;
  localparam logic [SizeW-1:0]  InitMaxRst  = 16'd1200;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [SizeW-1:0]  SizeMax  = '1;

  typedef enum logic [ModeW-1:0] {
    MODE_SENT  = 3'd0,
    MODE_ACK   = 3'd1,
    MODE_LOST  = 3'd2,
    MODE_BHOLE = 3'd3,
    MODE_SETMX = 3'd4,
    MODE_QUERY = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INFLIGHT = 2'd1,
    ST_INVALID  = 2'd2
  } status_t;

  typedef enum logic [IdxW-1:0] {
    REG_BASE    = 2'd0,
    REG_RETRY   = 2'd1,
    REG_INITMAX = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_BASE      = 2'd0,
    PH_SEARCHING = 2'd1,
    PH_COMPLETE  = 2'd2,
    PH_ERROR     = 2'd3
  } phase_t;

  typedef struct packed {
    logic [SizeW-1:0]  max_sz;
    logic [SizeW-1:0]  validated;
    logic [SizeW-1:0]  floor;
    logic [SizeW-1:0]  ceiling;
    logic [SizeW-1:0]  pending;
    logic [CountW-1:0] attempts;
    logic              outstanding;
    logic [SizeW-1:0]  bh_total;
    phase_t            phase;
  } search_t;

  // result item, lowest field in the lowest bits
  typedef struct packed {
    logic [1:0]       pad;
    logic [SizeW-1:0] blackholes_out;
    logic             validated_changed;
    logic             in_flight_out;
    logic [1:0]       search_state;
    logic [SizeW-1:0] validated_out;
    logic [SizeW-1:0] next_probe;
    logic [1:0]       status;
  } result_t;

  function automatic logic [SizeW-1:0] min_f(input logic [SizeW-1:0] a,
                                              input logic [SizeW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [SizeW-1:0] max_f(input logic [SizeW-1:0] a,
                                              input logic [SizeW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic phase_t phase_f(input search_t s, input logic [SizeW-1:0] base);
    phase_t p;
    if (s.validated < base) p = PH_ERROR;
    else if (s.validated == base) p = s.outstanding ? PH_SEARCHING : PH_BASE;
    else if (s.ceiling <= s.validated) p = PH_COMPLETE;
    else p = PH_SEARCHING;
    return p;
  endfunction

  function automatic search_t clear_f(input search_t s);
    search_t r;
    r = s;
    r.pending     = '0;
    r.attempts    = '0;
    r.outstanding = 1'b0;
    return r;
  endfunction

  function automatic search_t clamp_f(input search_t s);
    search_t r;
    r = s;
    r.validated = min_f(r.validated, r.max_sz);
    r.floor     = r.validated;
    r.ceiling   = max_f(min_f(r.ceiling, r.max_sz), r.floor);
    if (r.pending <= r.validated || r.pending > r.ceiling) r = clear_f(r);
    return r;
  endfunction

  function automatic search_t init_f(input logic [SizeW-1:0] base,
                                     input logic [SizeW-1:0] imax);
    search_t r;
    r.max_sz      = (imax == '0) ? base : imax;
    r.validated   = min_f(base, r.max_sz);
    r.floor       = r.validated;
    r.ceiling     = r.max_sz;
    r.pending     = '0;
    r.attempts    = '0;
    r.outstanding = 1'b0;
    r.bh_total    = '0;
    r.phase       = PH_BASE;
    r.phase       = phase_f(r, base);
    return r;
  endfunction

  // upward-rounded midpoint, zero when the range is empty
  function automatic logic [SizeW-1:0] mid_f(input logic [SizeW-1:0] lo,
                                              input logic [SizeW-1:0] hi);
    logic [SizeW:0] half;
    logic [SizeW:0] sum;
    half = ({1'b0, hi} - {1'b0, lo} + {{SizeW{1'b0}}, 1'b1}) >> 1;
    sum  = {1'b0, lo} + half;
    return (hi <= lo) ? '0 : sum[SizeW-1:0];
  endfunction

  function automatic logic [SizeW-1:0] next_f(input search_t s);
    logic [SizeW-1:0] r;
    if (s.outstanding) r = s.pending;
    else if (s.pending > s.validated && s.attempts != '0) r = s.pending;
    else r = mid_f(s.floor, s.ceiling);
    return r;
  endfunction

endpackage

>>> hw/rtl/path_mtu_probe_search.sv
// Each item is held in the input register and then its result in the result register,
// which loads only while the output can advance.
// Throughput: one event per cycle unless out_tready stalls the output; the search state
// updates in one pass as the input register drains into the result register.
// Reset (rst_n low, synchronous): registers return to base 1200, retry limit 3,
// initial maximum 1200, and the search state is initialized from them.
module path_mtu_probe_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pmtu_pkg::InDataW-1:0]       in_tdata,   // [15:0] size_value
  input  logic [pmtu_pkg::InUserW-1:0]       in_tuser,   // [2:0] mode, rest zero
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [17:2] next_probe, [33:18] validated_out, [35:34] search_state,
  // [36] in_flight_out, [37] validated_changed, [53:38] blackholes_out, rest zero
  output logic [pmtu_pkg::OutDataW-1:0]      out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pmtu_pkg::IdxW-1:0]          cfg_index,
  input  logic [pmtu_pkg::SizeW-1:0]         cfg_data
);
  import pmtu_pkg::*;

  logic [SizeW-1:0]  base_r;
  logic [CountW-1:0] retry_r;

  search_t st_r, st_nxt, st_item;

  logic             s1_vld_r;
  logic [ModeW-1:0] s1_mode_r;
  logic [SizeW-1:0] s1_size_r;

  logic    out_vld_r;
  result_t out_r, res_nxt;

  logic out_adv, s1_fire, in_fire, cfg_fire;

  assign out_adv   = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_adv;
  assign in_tready = !s1_vld_r || out_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = !s1_vld_r;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  always_comb begin
    search_t          s;
    logic [1:0]       status;
    logic             changed;
    logic [SizeW-1:0] sz;
    s       = st_r;
    status  = ST_OK;
    changed = 1'b0;
    sz      = s1_size_r;
    case (s1_mode_r)
      MODE_SENT: begin
        if (s.outstanding) begin
          status = ST_INFLIGHT;
        end else if (sz <= s.validated || sz > s.ceiling) begin
          status = ST_INVALID;
        end else begin
          s.outstanding = 1'b1;
          s.pending     = sz;
          if (s.attempts != CountMax) s.attempts = s.attempts + 1'b1;
          s.phase = PH_SEARCHING;
        end
      end
      MODE_ACK: begin
        if (!s.outstanding || s.pending != sz) begin
          status = ST_INVALID;
        end else begin
          s.validated = min_f(sz, s.max_sz);
          s.floor     = s.validated;
          s           = clear_f(s);
          s.phase     = phase_f(s, base_r);
          changed     = (s.validated != st_r.validated);
        end
      end
      MODE_LOST: begin
        if (!s.outstanding || s.pending != sz) begin
          status = ST_INVALID;
        end else begin
          s.outstanding = 1'b0;
          if (s.attempts < retry_r) begin
            s.phase = PH_SEARCHING;
          end else begin
            s.pending  = '0;
            s.attempts = '0;
            if (sz != '0) s.ceiling = sz - 1'b1;
            s.ceiling = max_f(s.ceiling, s.floor);
            s.phase   = phase_f(s, base_r);
          end
        end
      end
      MODE_BHOLE: begin
        if (s.bh_total != SizeMax) s.bh_total = s.bh_total + 1'b1;
        s.validated = min_f(base_r, s.max_sz);
        s.floor     = s.validated;
        s.ceiling   = s.validated;
        s           = clear_f(s);
        s.phase     = PH_ERROR;
        changed     = (s.validated != st_r.validated);
      end
      MODE_SETMX: begin
        s.max_sz = (sz == '0) ? base_r : sz;
        s        = clamp_f(s);
        s.phase  = phase_f(s, base_r);
      end
      MODE_QUERY: begin
      end
      default: begin
        status = ST_INVALID;
      end
    endcase
    st_item = s;
    res_nxt.pad               = '0;
    res_nxt.blackholes_out    = s.bh_total;
    res_nxt.validated_changed = changed;
    res_nxt.in_flight_out     = s.outstanding;
    res_nxt.search_state      = s.phase;
    res_nxt.validated_out     = s.validated;
    res_nxt.next_probe        = next_f(s);
    res_nxt.status            = status;
  end

  always_comb begin
    search_t s;
    s = st_r;
    if (cfg_fire) begin
      case (cfg_index)
        REG_BASE: begin
          if (s.max_sz == '0) s.max_sz = cfg_data;
          s       = clamp_f(s);
          s.phase = phase_f(s, cfg_data);
        end
        REG_INITMAX: s = init_f(base_r, cfg_data);
        default: begin
        end
      endcase
    end else if (s1_fire) begin
      s = st_item;
    end
    st_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= BaseSizeRst;
      retry_r   <= RetryRst;
      st_r      <= init_f(BaseSizeRst, InitMaxRst);
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_fire) begin
        case (cfg_index)
          REG_BASE:  base_r  <= cfg_data;
          REG_RETRY: retry_r <= cfg_data[CountW-1:0];
          default: begin
          end
        endcase
      end
      if (in_tready) s1_vld_r <= in_tvalid;
      if (out_adv) out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_tuser[ModeW-1:0];
      s1_size_r <= in_tdata[SizeW-1:0];
    end
    if (s1_fire) out_r <= res_nxt;
  end

  a_floor_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.floor == st_r.validated)
    else $error("search floor differs from validated size");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.ceiling >= st_r.floor)
    else $error("search ceiling below floor");

  a_probe_above: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.outstanding |-> (st_r.pending > st_r.validated))
    else $error("outstanding probe not above validated size");

  a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_fire && !cfg_fire) |=> $stable(st_r))
    else $error("search state changed without an item or write");

  a_valid_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.validated <= st_r.max_sz)
    else $error("validated size above maximum");

endmodule

>>> tb/sv/tb.sv
module tb;
  import pmtu_pkg::*;

  localparam logic [ModeW-1:0] MODE_SPARE_A = 3'd6;
  localparam logic [ModeW-1:0] MODE_SPARE_B = 3'd7;
  localparam logic [IdxW-1:0]  REG_UNUSED   = 2'd3;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 40;
  localparam int RETRY_BURST  = 120;
  localparam int BHOLE_FLOOD  = 40;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef enum logic [1:0] {ROW_EVT, ROW_CHK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [2:0]       code;
    logic [SizeW-1:0] val;
    result_t          want;
  } row_t;

  typedef struct packed {
    logic [SizeW-1:0]  max_sz;
    logic [SizeW-1:0]  valid_sz;
    logic [SizeW-1:0]  floor_sz;
    logic [SizeW-1:0]  ceil_sz;
    logic [SizeW-1:0]  probe_sz;
    logic [SizeW-1:0]  bh_count;
    logic [CountW-1:0] tries;
    logic              busy;
    phase_t            ph;
  } path_state_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata;
  logic [InUserW-1:0]  in_tuser;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index;
  logic [SizeW-1:0]    cfg_data;

  path_state_t      path;
  logic [SizeW-1:0] base_reg;
  logic [SizeW-1:0] initmax_reg;
  logic [CountW-1:0] retry_reg;

  result_t probe_results_q[$];
  row_t    plan[$];
  bit      calm  = 1'b0;
  bit      flood = 1'b0;
  int      mism_count = 0;
  int      results_seen = 0;
  int      ticks = 0;

  path_mtu_probe_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic phase_t phase_of();
    phase_t p;
    if (path.valid_sz < base_reg) p = PH_ERROR;
    else if (path.valid_sz == base_reg) p = path.busy ? PH_SEARCHING : PH_BASE;
    else if (path.ceil_sz <= path.valid_sz) p = PH_COMPLETE;
    else p = PH_SEARCHING;
    return p;
  endfunction

  function automatic void drop_probe();
    path.probe_sz = '0;
    path.tries    = '0;
    path.busy     = 1'b0;
  endfunction

  function automatic void clamp_to_max();
    if (path.max_sz < path.valid_sz) path.valid_sz = path.max_sz;
    path.floor_sz = path.valid_sz;
    if (path.max_sz < path.ceil_sz) path.ceil_sz = path.max_sz;
    if (path.ceil_sz < path.floor_sz) path.ceil_sz = path.floor_sz;
    if (path.probe_sz <= path.valid_sz || path.probe_sz > path.ceil_sz) drop_probe();
  endfunction

  function automatic void restart_search();
    path.max_sz   = (initmax_reg == '0) ? base_reg : initmax_reg;
    path.valid_sz = (base_reg < path.max_sz) ? base_reg : path.max_sz;
    path.floor_sz = path.valid_sz;
    path.ceil_sz  = path.max_sz;
    drop_probe();
    path.bh_count = '0;
    path.ph       = phase_of();
  endfunction

  function automatic logic [SizeW-1:0] probe_hint();
    logic [SizeW:0]   gap;
    logic [SizeW-1:0] hint;
    gap = {1'b0, path.ceil_sz} - {1'b0, path.floor_sz} + 17'd1;
    if (path.busy || (path.probe_sz > path.valid_sz && path.tries != '0)) hint = path.probe_sz;
    else if (path.ceil_sz <= path.floor_sz) hint = '0;
    else hint = path.floor_sz + gap[SizeW:1];
    return hint;
  endfunction

  function automatic void apply_reg(logic [IdxW-1:0] idx, logic [SizeW-1:0] v);
    case (idx)
      REG_BASE: begin
        base_reg = v;
        if (path.max_sz == '0) path.max_sz = base_reg;
        clamp_to_max();
        path.ph = phase_of();
      end
      REG_RETRY: retry_reg = v[CountW-1:0];
      REG_INITMAX: begin
        initmax_reg = v;
        restart_search();
      end
      default: ;
    endcase
  endfunction

  function automatic result_t advance_search(logic [2:0] mode, logic [SizeW-1:0] sz);
    result_t          r;
    status_t          st;
    logic             chg;
    logic [SizeW-1:0] prev;
    st   = ST_OK;
    chg  = 1'b0;
    prev = path.valid_sz;
    case (mode)
      MODE_SENT: begin
        if (path.busy) st = ST_INFLIGHT;
        else if (sz <= path.valid_sz || sz > path.ceil_sz) st = ST_INVALID;
        else begin
          path.busy     = 1'b1;
          path.probe_sz = sz;
          if (path.tries != CountMax) path.tries = path.tries + 1'b1;
          path.ph = PH_SEARCHING;
        end
      end
      MODE_ACK: begin
        if (!path.busy || path.probe_sz != sz) st = ST_INVALID;
        else begin
          path.valid_sz = (sz < path.max_sz) ? sz : path.max_sz;
          path.floor_sz = path.valid_sz;
          drop_probe();
          path.ph = phase_of();
          chg = (path.valid_sz != prev);
        end
      end
      MODE_LOST: begin
        if (!path.busy || path.probe_sz != sz) st = ST_INVALID;
        else begin
          path.busy = 1'b0;
          if (path.tries < retry_reg) path.ph = PH_SEARCHING;
          else begin
            path.probe_sz = '0;
            path.tries    = '0;
            if (sz != '0) path.ceil_sz = sz - 1'b1;
            if (path.ceil_sz < path.floor_sz) path.ceil_sz = path.floor_sz;
            path.ph = phase_of();
          end
        end
      end
      MODE_BHOLE: begin
        if (path.bh_count != SizeMax) path.bh_count = path.bh_count + 1'b1;
        path.valid_sz = (base_reg < path.max_sz) ? base_reg : path.max_sz;
        path.floor_sz = path.valid_sz;
        path.ceil_sz  = path.valid_sz;
        drop_probe();
        path.ph = PH_ERROR;
        chg = (path.valid_sz != prev);
      end
      MODE_SETMX: begin
        path.max_sz = (sz == '0) ? base_reg : sz;
        clamp_to_max();
        path.ph = phase_of();
      end
      MODE_QUERY: ;
      default: st = ST_INVALID;
    endcase
    r                   = '0;
    r.status            = st;
    r.next_probe        = probe_hint();
    r.validated_out     = path.valid_sz;
    r.search_state      = path.ph;
    r.in_flight_out     = path.busy;
    r.validated_changed = chg;
    r.blackholes_out    = path.bh_count;
    return r;
  endfunction

  function automatic row_t evt(logic [2:0] m, logic [SizeW-1:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_EVT;
    r.code = m;
    r.val  = v;
    return r;
  endfunction

  // only used while the path still holds its reset values
  function automatic row_t chk(logic [2:0] m, logic [SizeW-1:0] v, status_t st);
    row_t r;
    r                      = '0;
    r.kind                 = ROW_CHK;
    r.code                 = m;
    r.val                  = v;
    r.want.status          = st;
    r.want.next_probe      = 16'd0;
    r.want.validated_out   = 16'd1200;
    r.want.search_state    = PH_BASE;
    r.want.blackholes_out  = 16'd0;
    return r;
  endfunction

  function automatic row_t wreg(logic [IdxW-1:0] idx, logic [SizeW-1:0] v);
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.code = {1'b0, idx};
    r.val  = v;
    return r;
  endfunction

  task automatic report(string what, logic [SizeW-1:0] got, logic [SizeW-1:0] want);
    if (mism_count < 40)
      $display("cycle %0d: %s got %0d want %0d", ticks, what, got, want);
    mism_count++;
  endtask

  task automatic push_item(logic [2:0] mode, logic [SizeW-1:0] sz, bit typed, result_t want);
    result_t pred;
    if (!calm && $urandom_range(99) < 9) begin
      @(negedge clk) in_tvalid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = sz;
    in_tuser  = {{(InUserW-ModeW){1'b0}}, mode};
    do @(posedge clk); while (!in_tready);
    pred = advance_search(mode, sz);
    probe_results_q.push_back(typed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk) in_tvalid = 1'b0;
    while (probe_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [SizeW-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, v);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic pick_event(input int wf_pct, input int lose_pct,
                            output logic [2:0] m, output logic [SizeW-1:0] s);
    int               roll;
    logic [SizeW-1:0] hint;
    roll = $urandom_range(99);
    hint = probe_hint();
    s    = 16'($urandom);
    if (flood) m = MODE_BHOLE;
    else if (roll < wf_pct) begin
      if (path.busy) begin
        m = ($urandom_range(99) < lose_pct) ? MODE_LOST : MODE_ACK;
        s = path.probe_sz;
      end else if (hint != '0) begin
        m = MODE_SENT;
        s = hint;
        if ($urandom_range(4) == 0 && path.ceil_sz > path.valid_sz)
          s = 16'($urandom_range(int'(path.valid_sz) + 1, int'(path.ceil_sz)));
      end else begin
        m = $urandom_range(1) ? MODE_QUERY : MODE_SETMX;
      end
    end else if (roll < wf_pct + 5) begin
      m = MODE_SETMX;
      if ($urandom_range(3) == 0) s = '0;
    end else if (roll < wf_pct + 9) m = MODE_BHOLE;
    else if (roll < wf_pct + 13) m = MODE_QUERY;
    else if (roll < wf_pct + 16) m = $urandom_range(1) ? MODE_SPARE_A : MODE_SPARE_B;
    else begin
      m = 3'($urandom_range(2));
      if ($urandom_range(1)) s = path.probe_sz + 1'b1;
    end
  endtask

  always @(negedge clk) out_tready = calm || ($urandom_range(99) >= 9);

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      results_seen++;
      if (probe_results_q.size() == 0)
        report("result with no item pending", 16'(got.status), 16'd0);
      else begin
        want = probe_results_q.pop_front();
        if (got.status !== want.status)
          report("status", 16'(got.status), 16'(want.status));
        if (got.next_probe !== want.next_probe)
          report("next_probe", got.next_probe, want.next_probe);
        if (got.validated_out !== want.validated_out)
          report("validated_out", got.validated_out, want.validated_out);
        if (got.search_state !== want.search_state)
          report("search_state", 16'(got.search_state), 16'(want.search_state));
        if (got.in_flight_out !== want.in_flight_out)
          report("in_flight_out", 16'(got.in_flight_out), 16'(want.in_flight_out));
        if (got.validated_changed !== want.validated_changed)
          report("validated_changed", 16'(got.validated_changed),
                 16'(want.validated_changed));
        if (got.blackholes_out !== want.blackholes_out)
          report("blackholes_out", got.blackholes_out, want.blackholes_out);
      end
    end
  end

  always @(posedge clk) begin
    ticks++;
    if (ticks > CYCLE_LIMIT) begin
      $display("Run stopped at cycle limit with %0d items pending", probe_results_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [2:0]       m;
    logic [SizeW-1:0] s;
    logic [SizeW-1:0] bv;
    logic [SizeW-1:0] mv;
    logic [CountW-1:0] rv;
    int               ph;
    int               n;
    int               dir_items;
    int               rand_items;
    int               reg_writes;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    base_reg    = BaseSizeRst;
    retry_reg   = RetryRst;
    initmax_reg = InitMaxRst;
    restart_search();
    dir_items  = 0;
    rand_items = 0;
    reg_writes = 0;

    plan.push_back(chk(MODE_QUERY,   16'h0000, ST_OK));
    plan.push_back(chk(MODE_SPARE_A, 16'hFFFF, ST_INVALID));
    plan.push_back(chk(MODE_SPARE_B, 16'h0000, ST_INVALID));
    plan.push_back(chk(MODE_SENT,    16'd1200, ST_INVALID));
    plan.push_back(chk(MODE_ACK,     16'h0000, ST_INVALID));
    plan.push_back(chk(MODE_LOST,    16'hFFFF, ST_INVALID));
    plan.push_back(evt(MODE_SETMX,   16'h0000));
    plan.push_back(wreg(REG_INITMAX, 16'hFFFF));
    plan.push_back(evt(MODE_SENT,    16'hFFFF));
    plan.push_back(evt(MODE_SENT,    16'd2000));
    plan.push_back(evt(MODE_ACK,     16'd2000));
    plan.push_back(evt(MODE_LOST,    16'hFFFF));
    plan.push_back(evt(MODE_SENT,    16'hFFFF));
    plan.push_back(evt(MODE_LOST,    16'hFFFF));
    plan.push_back(evt(MODE_SENT,    16'hFFFF));
    plan.push_back(evt(MODE_LOST,    16'hFFFF));
    plan.push_back(evt(MODE_SENT,    16'd1500));
    plan.push_back(evt(MODE_ACK,     16'd1500));
    plan.push_back(evt(MODE_SENT,    16'hFFFE));
    plan.push_back(evt(MODE_SETMX,   16'd40000));
    plan.push_back(evt(MODE_BHOLE,   16'h0000));
    plan.push_back(wreg(REG_RETRY,   16'h0100));
    plan.push_back(wreg(REG_INITMAX, 16'd2000));
    plan.push_back(evt(MODE_SENT,    16'd1201));
    plan.push_back(evt(MODE_LOST,    16'd1201));
    plan.push_back(wreg(REG_BASE,    16'h0000));
    plan.push_back(evt(MODE_SETMX,   16'h0000));
    plan.push_back(wreg(REG_INITMAX, 16'h0000));
    plan.push_back(wreg(REG_BASE,    16'hFFFF));
    plan.push_back(evt(MODE_BHOLE,   16'hFFFF));
    plan.push_back(wreg(REG_UNUSED,  16'hFFFF));
    plan.push_back(wreg(REG_RETRY,   16'd3));

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].code[IdxW-1:0], plan[i].val);
        reg_writes++;
      end else begin
        push_item(plan[i].code, plan[i].val, plan[i].kind == ROW_CHK, plan[i].want);
        dir_items++;
      end
    end

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case ($urandom_range(9))
        0:       bv = 16'd1;
        1:       bv = 16'hFFFF;
        2:       bv = 16'd0;
        3:       bv = 16'($urandom);
        default: bv = 16'($urandom_range(1, 4000));
      endcase
      case ($urandom_range(9))
        0:       mv = 16'd0;
        1:       mv = 16'hFFFF;
        2:       mv = 16'd1;
        3:       mv = 16'($urandom);
        default: mv = 16'($urandom_range(int'(bv), 65535));
      endcase
      case ($urandom_range(9))
        0:       rv = 8'd0;
        1:       rv = 8'd255;
        2:       rv = 8'd1;
        default: rv = 8'($urandom_range(1, 6));
      endcase
      case (ph % 4)
        1: begin
          write_reg(REG_BASE, bv);
          reg_writes += 1;
        end
        2: begin
          write_reg(REG_INITMAX, mv);
          write_reg(REG_BASE, bv);
          write_reg(REG_RETRY, {8'($urandom), rv});
          reg_writes += 3;
        end
        default: begin
          write_reg(REG_RETRY, {8'($urandom), rv});
          write_reg(REG_BASE, bv);
          write_reg(REG_INITMAX, mv);
          reg_writes += 3;
        end
      endcase
      calm = (ph == 5);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == 25) drain();
        pick_event(75, 50, m, s);
        push_item(m, s, 1'b0, '0);
        rand_items++;
      end
      calm = 1'b0;
    end

    // retry limit at its top, long retry runs on one probe size
    drain();
    write_reg(REG_RETRY, 16'h00FF);
    write_reg(REG_BASE, 16'd100);
    write_reg(REG_INITMAX, 16'd60000);
    reg_writes += 3;
    for (n = 0; n < RETRY_BURST; n++) begin
      pick_event(100, 100, m, s);
      push_item(m, s, 1'b0, '0);
      rand_items++;
    end

    // black hole run, no idling on either side
    drain();
    write_reg(REG_INITMAX, 16'd9000);
    reg_writes += 1;
    calm  = 1'b1;
    flood = 1'b1;
    for (n = 0; n < BHOLE_FLOOD; n++) begin
      pick_event(100, 50, m, s);
      push_item(m, s, 1'b0, '0);
      rand_items++;
    end
    flood = 1'b0;
    calm  = 1'b0;

    drain();
    repeat (6) @(posedge clk);
    $display("Ran %0d table items, %0d generated items and %0d register writes",
             dir_items, rand_items, reg_writes);
    $display("Checked %0d results field by field, %0d field errors", results_seen, mism_count);
    if (mism_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
